[hdl/merge_by_rank_search_unit_defines.svh]
// assertion helpers for the merge by rank search unit
`ifndef MERGE_BY_RANK_SEARCH_UNIT_DEFINES_SVH
`define MERGE_BY_RANK_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MBRS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbrs assertion failed");
`define MBRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbrs assertion failed");
`else
`define MBRS_ASSERT_IMPLIES(lbl, ante, cons)
`define MBRS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/mbrs_pkg.sv]
package mbrs_pkg;

  localparam int WORD_W        = 32;
  localparam int INDEX_W       = 8;
  localparam int LEN_W         = 9;
  localparam int POS_W         = 9;
  localparam int DEPTH_DEFAULT = 256;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  typedef enum logic [1:0] {
    KIND_LOAD_FIRST   = 2'd0,
    KIND_LOAD_SECOND  = 2'd1,
    KIND_PLACE_FIRST  = 2'd2,
    KIND_PLACE_SECOND = 2'd3
  } kind_t;

  // memory control from the search sequencer to the two arrays
  typedef struct packed {
    logic we_first;
    logic we_second;
    logic own_first;
  } mem_ctl_t;

endpackage

[hdl/mbrs_ram.sv]
module mbrs_ram #(
  parameter int DEPTH = mbrs_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mbrs_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [mbrs_pkg::WORD_W-1:0] rdata
);

  logic [mbrs_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/mbrs_ctrl.sv]
`include "merge_by_rank_search_unit_defines.svh"

module mbrs_ctrl #(
  parameter int DEPTH = mbrs_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         kind,
  input  logic [mbrs_pkg::INDEX_W-1:0]       index,
  input  logic signed [mbrs_pkg::WORD_W-1:0] value,
  input  logic [CW-1:0]                      len_eff,
  input  logic [mbrs_pkg::WORD_W-1:0]        rdata_first,
  input  logic [mbrs_pkg::WORD_W-1:0]        rdata_second,
  output logic                               busy,
  output mbrs_pkg::mem_ctl_t                 mem_ctl,
  output logic [AW-1:0]                      waddr,
  output logic [mbrs_pkg::WORD_W-1:0]        wdata,
  output logic [AW-1:0]                      own_addr,
  output logic [AW-1:0]                      probe_addr,
  output logic                               done,
  output logic [mbrs_pkg::POS_W-1:0]         position,
  output logic signed [mbrs_pkg::WORD_W-1:0] element
);

  localparam int LW = (CW > mbrs_pkg::LEN_W) ? CW : mbrs_pkg::LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t                       state;
  logic                         own_first;
  logic [mbrs_pkg::INDEX_W-1:0] idx_q;
  logic [CW-1:0]                lo;
  logic [CW-1:0]                hi;
  logic [CW-1:0]                mid;

  mbrs_pkg::kind_t             kind_in;
  logic                        accept;
  logic                        load_ok;
  logic                        place_ok;
  logic                        place_go;
  logic                        own_first_in;
  logic [mbrs_pkg::WORD_W-1:0] key;
  logic [mbrs_pkg::WORD_W-1:0] probe;
  logic                        go_up;
  logic [CW-1:0]               up_lo;
  logic [CW-1:0]               up_mid;
  logic [CW-1:0]               dn_mid;
  logic [CW-1:0]               lo_next;
  logic [CW-1:0]               hi_next;
  logic [CW-1:0]               mid_next;
  logic                        more;

  assign kind_in  = mbrs_pkg::kind_t'(kind);
  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign load_ok  = LW'(index) < LW'(DEPTH);
  assign place_ok = LW'(index) < LW'(len_eff);
  assign own_first_in = (kind_in == mbrs_pkg::KIND_PLACE_FIRST);

  always_comb begin
    mem_ctl.we_first  = 1'b0;
    mem_ctl.we_second = 1'b0;
    mem_ctl.own_first = (state == ST_SEARCH) ? own_first : own_first_in;
    place_go          = 1'b0;
    unique case (kind_in)
      mbrs_pkg::KIND_LOAD_FIRST:   mem_ctl.we_first  = accept && load_ok;
      mbrs_pkg::KIND_LOAD_SECOND:  mem_ctl.we_second = accept && load_ok;
      mbrs_pkg::KIND_PLACE_FIRST:  place_go          = accept && place_ok;
      mbrs_pkg::KIND_PLACE_SECOND: place_go          = accept && place_ok;
      default:                     place_go          = 1'b0;
    endcase
  end

  assign waddr = AW'(index);
  assign wdata = $unsigned(value);

  // own array keeps reading the placed element so its word stays on rdata
  assign key   = own_first ? rdata_first : rdata_second;
  assign probe = own_first ? rdata_second : rdata_first;

  // second-array elements also step past equal first-array words
  assign go_up = ($signed(probe) < $signed(key)) || (!own_first && (probe == key));

  // both interval halves are prepared before the compare settles
  assign up_lo  = mid + CW'(1);
  assign up_mid = up_lo + ((hi - up_lo) >> 1);
  assign dn_mid = lo + ((mid - lo) >> 1);

  assign lo_next  = go_up ? up_lo : lo;
  assign hi_next  = go_up ? hi : mid;
  assign mid_next = go_up ? up_mid : dn_mid;
  assign more     = lo_next < hi_next;

  assign own_addr   = (state == ST_SEARCH) ? AW'(idx_q) : AW'(index);
  assign probe_addr = (state == ST_SEARCH) ? AW'(mid_next) : AW'(len_eff >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (place_go) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (!more) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      own_first <= own_first_in;
      idx_q     <= index;
      lo        <= '0;
      hi        <= len_eff;
      mid       <= len_eff >> 1;
    end else begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (!more) begin
        position <= mbrs_pkg::POS_W'(LW'(idx_q) + LW'(lo_next));
        element  <= $signed(key);
      end
    end
  end

  `MBRS_ASSERT_IMPLIES(a_interval_open, state == ST_SEARCH, lo < hi)
  `MBRS_ASSERT_IMPLIES(a_mid_inside, state == ST_SEARCH, (mid >= lo) && (mid < hi))
  `MBRS_ASSERT_IMPLIES(a_done_after_search, done, $past(state == ST_SEARCH))
  `MBRS_ASSERT_NEXT(a_load_no_word, accept && !kind[1], !done && (state == ST_IDLE))

endmodule

[hdl/merge_by_rank_search_unit.sv]
// merge by rank search unit
// holds two sorted arrays of signed 32-bit words and finds where an element
// of one array lands in the merged order by binary search over the other.
// input channel: an item is taken at a clock edge with start high and busy low.
//   kind 0/1 loads first/second array entry index with value and gives no
//   result word; kind 2/3 places first/second array element index.
// a place item reads its element and the first probe in the accept cycle, then
//   probes one word of the other array per cycle until its search interval
//   closes, halving it at each probe over the n entries in use; the
//   single read port of the searched array sets that pace. the result word
//   (position, element) shows for one cycle with done high, the cycle after the
//   last probe, and the next item may be taken in that same cycle.
// a place index not below the length in use is dropped without a result word.
// cfg_we writes cfg_data into the length in use; write only while idle.
// reset clears the sequencer and sets the length to 256; array contents are
// undefined until loaded. the receiver cannot stall: results are never held.
module merge_by_rank_search_unit #(
  parameter int DEPTH = mbrs_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         kind,
  input  logic [mbrs_pkg::INDEX_W-1:0]       index,
  input  logic signed [mbrs_pkg::WORD_W-1:0] value,
  input  logic                               cfg_we,
  input  logic [mbrs_pkg::LEN_W-1:0]         cfg_data,
  output logic                               busy,
  output logic                               done,
  output logic [mbrs_pkg::POS_W-1:0]         position,
  output logic signed [mbrs_pkg::WORD_W-1:0] element
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > mbrs_pkg::LEN_W) ? CW : mbrs_pkg::LEN_W;

  logic [mbrs_pkg::LEN_W-1:0]  length_in_use;
  logic [CW-1:0]               len_eff;
  mbrs_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]               waddr;
  logic [mbrs_pkg::WORD_W-1:0] wdata;
  logic [AW-1:0]               own_addr;
  logic [AW-1:0]               probe_addr;
  logic [AW-1:0]               raddr_first;
  logic [AW-1:0]               raddr_second;
  logic [mbrs_pkg::WORD_W-1:0] rdata_first;
  logic [mbrs_pkg::WORD_W-1:0] rdata_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= mbrs_pkg::LEN_RESET;
    end else if (cfg_we) begin
      length_in_use <= cfg_data;
    end
  end

  // saturate the length to the array depth
  assign len_eff = (LW'(length_in_use) > LW'(DEPTH)) ? CW'(DEPTH) : CW'(length_in_use);

  assign raddr_first  = mem_ctl.own_first ? own_addr : probe_addr;
  assign raddr_second = mem_ctl.own_first ? probe_addr : own_addr;

  mbrs_ram #(.DEPTH(DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (mem_ctl.we_first),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_first),
    .rdata (rdata_first)
  );

  mbrs_ram #(.DEPTH(DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (mem_ctl.we_second),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_second),
    .rdata (rdata_second)
  );

  mbrs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .index        (index),
    .value        (value),
    .len_eff      (len_eff),
    .rdata_first  (rdata_first),
    .rdata_second (rdata_second),
    .busy         (busy),
    .mem_ctl      (mem_ctl),
    .waddr        (waddr),
    .wdata        (wdata),
    .own_addr     (own_addr),
    .probe_addr   (probe_addr),
    .done         (done),
    .position     (position),
    .element      (element)
  );

endmodule

[bench/tb_merge_by_rank_search_unit.sv]
module tb_merge_by_rank_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mbrs_pkg::kind_t kind;
    logic [7:0]      index;
    logic [31:0]     value;
  } cmd_word_t;

  typedef struct packed {
    logic [8:0]  position;
    logic [31:0] element;
  } placed_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] kind = '0;
  logic [mbrs_pkg::INDEX_W-1:0] index = '0;
  logic signed [mbrs_pkg::WORD_W-1:0] value = '0;
  logic cfg_we = 1'b0;
  logic [mbrs_pkg::LEN_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [mbrs_pkg::POS_W-1:0] position;
  logic signed [mbrs_pkg::WORD_W-1:0] element;

  cmd_word_t    cmd_q[$];
  placed_word_t placed_q[$];
  cmd_word_t    cur_cmd;
  placed_word_t got_word;

  // shadow copies of the two sorted arrays and the length register
  logic [31:0] first_shadow[256];
  logic [31:0] second_shadow[256];
  logic [8:0]  len_shadow = mbrs_pkg::LEN_RESET;

  int n_queued = 0;
  int n_taken = 0;
  int n_errors = 0;
  int burst_left = 0;
  int gap_left = 0;

  merge_by_rank_search_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .index    (index),
    .value    (value),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .busy     (busy),
    .done     (done),
    .position (position),
    .element  (element)
  );

  always #5 clk = ~clk;

  // binary search for the rank of key in the other array
  function automatic logic [8:0] rank_of(bit in_first, int unsigned n, logic [31:0] key,
                                         bit or_equal);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [31:0] probe;
    bit go_up;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      probe = in_first ? first_shadow[mid] : second_shadow[mid];
      go_up = ($signed(probe) < $signed(key)) || (or_equal && probe == key);
      if (go_up) lo = mid + 1;
      else hi = mid;
    end
    return lo[8:0];
  endfunction

  function automatic void apply_cmd(cmd_word_t c);
    int unsigned n;
    placed_word_t w;
    n = (len_shadow > 9'd256) ? 256 : len_shadow;
    case (c.kind)
      mbrs_pkg::KIND_LOAD_FIRST: first_shadow[c.index] = c.value;
      mbrs_pkg::KIND_LOAD_SECOND: second_shadow[c.index] = c.value;
      default: begin
        if (c.index < n) begin
          if (c.kind == mbrs_pkg::KIND_PLACE_FIRST) begin
            w.element = first_shadow[c.index];
            w.position = 9'(c.index) + rank_of(1'b0, n, w.element, 1'b0);
          end else begin
            w.element = second_shadow[c.index];
            w.position = 9'(c.index) + rank_of(1'b1, n, w.element, 1'b1);
          end
          placed_q.push_back(w);
        end
      end
    endcase
  endfunction

  // driver: presents queued words in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_cmd(cur_cmd);
        n_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          kind <= cur_cmd.kind;
          index <= cur_cmd.index;
          value <= cur_cmd.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (placed_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got position %0d element %0d",
                 $time, position, element);
        n_errors++;
      end else begin
        got_word = placed_q.pop_front();
        if (position !== got_word.position) begin
          $display("%0t: position expected %0d got %0d", $time, got_word.position, position);
          n_errors++;
        end
        if (element !== got_word.element) begin
          $display("%0t: element expected %0d got %0d", $time, $signed(got_word.element),
                   element);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word(int mode);
    int m;
    m = (mode == 3) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return $urandom;
      1: return $urandom_range(0, 6) - 3;
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                            : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic push_cmd(mbrs_pkg::kind_t k, int unsigned idx, logic [31:0] v);
    cmd_word_t c;
    c.kind = k;
    c.index = idx[7:0];
    c.value = v;
    cmd_q.push_back(c);
    n_queued++;
  endtask

  // load entries [0, n) of both arrays, sorted unless told otherwise
  task automatic load_arrays(int unsigned n, bit in_order);
    logic signed [31:0] word_buf[2][256];
    logic signed [31:0] t;
    int mode;
    int j;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      word_buf[0][i] = rand_word(mode);
      word_buf[1][i] = rand_word(mode);
    end
    if (in_order) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 1; i < n; i++) begin
          t = word_buf[s][i];
          j = i - 1;
          while (j >= 0 && word_buf[s][j] > t) begin
            word_buf[s][j+1] = word_buf[s][j];
            j--;
          end
          word_buf[s][j+1] = t;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      push_cmd(mbrs_pkg::KIND_LOAD_FIRST, i, word_buf[0][i]);
      push_cmd(mbrs_pkg::KIND_LOAD_SECOND, i, word_buf[1][i]);
    end
  endtask

  // wait until every word is taken and every result has come back
  task automatic drain_idle();
    while (n_taken != n_queued || placed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_length(logic [8:0] len);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_data <= len;
    len_shadow = len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int random_items;
    int unsigned len;
    int unsigned eff;
    int unsigned n_load;
    int unsigned idx;
    int n_places;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // every entry written once so no search ever reads an unwritten word
    load_arrays(256, 1'b1);

    // extremes and ties at the default length
    push_cmd(mbrs_pkg::KIND_LOAD_FIRST, 0, 32'h80000000);
    push_cmd(mbrs_pkg::KIND_LOAD_SECOND, 0, 32'h80000000);
    push_cmd(mbrs_pkg::KIND_LOAD_FIRST, 255, 32'h7fffffff);
    push_cmd(mbrs_pkg::KIND_LOAD_SECOND, 255, 32'h7fffffff);
    push_cmd(mbrs_pkg::KIND_LOAD_FIRST, 128, 32'h00000000);
    push_cmd(mbrs_pkg::KIND_LOAD_SECOND, 128, 32'h00000000);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 0, 32'hffffffff);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 0, 32'h00000000);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 255, 32'h00000000);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 255, 32'hffffffff);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 128, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 128, 32'h0);

    // single entry, places past the end dropped, load accepted past the end
    set_length(9'd1);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 0, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 0, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 1, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 255, 32'h0);
    push_cmd(mbrs_pkg::KIND_LOAD_FIRST, 200, $urandom);

    // empty length: nothing can be placed
    set_length(9'd0);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 0, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 0, 32'h0);

    // lengths beyond the depth saturate
    set_length(9'd511);
    push_cmd(mbrs_pkg::KIND_PLACE_FIRST, 255, 32'h0);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 0, 32'h0);
    set_length(9'd300);
    push_cmd(mbrs_pkg::KIND_PLACE_SECOND, 255, 32'h0);

    // short random phase on top of the full load above
    while (random_items < 200) begin
      case ($urandom_range(0, 11))
        0: len = 1;
        1: len = 2;
        2: len = $urandom_range(3, 16);
        3: len = 256;
        4: len = 0;
        5: len = $urandom_range(257, 511);
        default: len = $urandom_range(3, 24);
      endcase
      set_length(len[8:0]);
      eff = (len > 256) ? 256 : len;
      // long lengths search what is already loaded
      if (eff <= 64) n_load = eff;
      else n_load = 0;
      // mostly sorted arrays, now and then unsorted content
      load_arrays(n_load, $urandom_range(0, 9) != 0);
      random_items += 2 * n_load;
      n_places = $urandom_range(8, 40);
      for (int p = 0; p < n_places; p++) begin
        if (eff < 256 && $urandom_range(0, 7) == 0) begin
          // noise load outside the searched range
          push_cmd($urandom_range(0, 1) ? mbrs_pkg::KIND_LOAD_SECOND
                                        : mbrs_pkg::KIND_LOAD_FIRST,
                   $urandom_range(eff, 255), $urandom);
          random_items++;
        end
        if (eff == 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, 255);
        else idx = $urandom_range(0, eff - 1);
        push_cmd($urandom_range(0, 1) ? mbrs_pkg::KIND_PLACE_SECOND
                                      : mbrs_pkg::KIND_PLACE_FIRST,
                 idx, $urandom);
        random_items++;
      end
    end

    drain_idle();
    if (placed_q.size() != 0) begin
      $display("%0t: %0d result words expected, got none", $time, placed_q.size());
      n_errors += placed_q.size();
    end
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
